// File: design/smsi_pkg.sv
// Shared types and constants of the segment micro step interpolator.
package smsi_pkg;

    localparam int STEP_W  = 7;   // step count and remainder width
    localparam int POS_W   = 24;  // Q16.8 position
    localparam int DIFF_W  = 25;  // position difference and its quotient
    localparam int PWR_W   = 16;  // Q0.16 power and output code
    localparam int PACC_W  = 18;  // accumulated power ramp, signed
    localparam int GAIN_W  = 16;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd3;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_PUSH
    } front_state_t;

    // One segment as handed from the front to the back: per-step quotient and
    // remainder of each difference over the step count.
    typedef struct packed {
        logic signed [DIFF_W-1:0] qdx;
        logic [STEP_W-1:0]        rdx;
        logic signed [DIFF_W-1:0] qdy;
        logic [STEP_W-1:0]        rdy;
        logic signed [PACC_W-1:0] qdp;
        logic [STEP_W-1:0]        rdp;
        logic [PWR_W-1:0]         p0;
        logic [STEP_W-1:0]        n;
    } seg_t;

endpackage

// File: design/smsi_div.sv
// Bit-serial floor divider: signed difference over a small positive step count.
module smsi_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [smsi_pkg::DIFF_W-1:0] dividend,
    input  logic [smsi_pkg::STEP_W-1:0]        divisor,
    output logic                               done,
    output logic signed [smsi_pkg::DIFF_W-1:0] quot,
    output logic [smsi_pkg::STEP_W-1:0]        rmd
);
    import smsi_pkg::*;

    localparam int CNT_W = $clog2(DIFF_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DIFF_W-1:0] mag_reg;
    logic [STEP_W-1:0] rem_reg;

    logic [STEP_W:0]   trial;
    logic              ge;
    logic [STEP_W:0]   trial_sub;

    assign trial     = {rem_reg, mag_reg[DIFF_W-1]};
    assign ge        = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIFF_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIFF_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift one quotient bit in per cycle; the remainder stays below the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIFF_W-1];
            mag_reg <= dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[DIFF_W-2:0], ge};
            rem_reg <= ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
        end
    end

    // Turn the truncated magnitude result into floor quotient and modulo.
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
        begin
            quot = -$signed(mag_reg) - DIFF_W'(1);
            rmd  = divisor - rem_reg;
        end
        else if (neg_reg)
        begin
            quot = -$signed(mag_reg);
            rmd  = '0;
        end
        else
        begin
            quot = $signed(mag_reg);
            rmd  = rem_reg;
        end
    end

    assign done = done_reg;

endmodule

// File: design/smsi_front.sv
// Front end: take points, keep the stored point, divide segment differences.
module smsi_front #(
    parameter int MAX_STEPS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [smsi_pkg::POS_W-1:0] x_pos,
    input  logic signed [smsi_pkg::POS_W-1:0] y_pos,
    input  logic [smsi_pkg::PWR_W-1:0]       power_level,
    input  logic                             first_point,
    input  logic [smsi_pkg::STEP_W-1:0]      steps_cfg,
    output logic                             push,
    output smsi_pkg::seg_t                   push_seg,
    input  logic                             q_full
);
    import smsi_pkg::*;

    front_state_t state_reg, state_next;

    logic                     have_start_reg;
    logic signed [POS_W-1:0]  prev_x_reg;
    logic signed [POS_W-1:0]  prev_y_reg;
    logic [PWR_W-1:0]         prev_p_reg;
    logic [PWR_W-1:0]         p0_reg;
    logic [STEP_W-1:0]        n_reg;

    logic                     in_fire;
    logic                     seg_fire;
    logic [STEP_W-1:0]        n_clamped;
    logic signed [DIFF_W-1:0] dx, dy, dp;
    logic                     div_start;
    logic [STEP_W-1:0]        div_n;
    logic                     done_x, done_y, done_p;
    logic signed [DIFF_W-1:0] qx, qy, qp;
    logic [STEP_W-1:0]        rx, ry, rp;

    assign in_fire  = in_valid && in_ready;
    assign seg_fire = in_fire && !first_point && have_start_reg;

    always_comb
    begin
        if (steps_cfg == '0)
            n_clamped = STEP_W'(1);
        else if (steps_cfg > STEP_W'(MAX_STEPS))
            n_clamped = STEP_W'(MAX_STEPS);
        else
            n_clamped = steps_cfg;
    end

    assign dx = DIFF_W'(x_pos) - DIFF_W'(prev_x_reg);
    assign dy = DIFF_W'(y_pos) - DIFF_W'(prev_y_reg);
    assign dp = DIFF_W'({1'b0, power_level}) - DIFF_W'({1'b0, prev_p_reg});

    // All three lanes run in lockstep; wait for every one of them.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (seg_fire)
                    state_next = FRONT_DIV;
            end
            FRONT_DIV:
            begin
                if (done_x && done_y && done_p)
                    state_next = FRONT_PUSH;
            end
            FRONT_PUSH:
            begin
                if (!q_full)
                    state_next = FRONT_IDLE;
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        case (state_reg)
            FRONT_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = seg_fire;
            end
            FRONT_PUSH:
            begin
                push = !q_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FRONT_IDLE;
            have_start_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                have_start_reg <= 1'b1;
                prev_x_reg     <= x_pos;
                prev_y_reg     <= y_pos;
                prev_p_reg     <= power_level;
            end
        end
    end

    // Hold the divisor and start power for the whole division.
    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            p0_reg <= prev_p_reg;
            n_reg  <= n_clamped;
        end
    end

    assign div_n = div_start ? n_clamped : n_reg;

    smsi_div u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dx),
        .divisor(div_n), .done(done_x), .quot(qx), .rmd(rx)
    );

    smsi_div u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dy),
        .divisor(div_n), .done(done_y), .quot(qy), .rmd(ry)
    );

    smsi_div u_div_p (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dp),
        .divisor(div_n), .done(done_p), .quot(qp), .rmd(rp)
    );

    always_comb
    begin
        push_seg.qdx = qx;
        push_seg.rdx = rx;
        push_seg.qdy = qy;
        push_seg.rdy = ry;
        push_seg.qdp = qp[PACC_W-1:0];
        push_seg.rdp = rp;
        push_seg.p0  = p0_reg;
        push_seg.n   = n_reg;
    end

endmodule

// File: design/smsi_queue.sv
// Two-entry segment queue between front end and step generator.
module smsi_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smsi_pkg::seg_t push_seg,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output smsi_pkg::seg_t q_seg
);
    import smsi_pkg::*;

    seg_t        mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_seg   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_seg;
    end

endmodule

// File: design/smsi_back.sv
// Back end: step generator, gain and power multipliers, rounding and output.
module smsi_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  smsi_pkg::seg_t                     q_seg,
    output logic                               pop,
    input  logic [smsi_pkg::GAIN_W-1:0]        x_gain,
    input  logic [smsi_pkg::GAIN_W-1:0]        y_gain,
    input  logic [smsi_pkg::PWR_W-1:0]         full_scale,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [smsi_pkg::OUT_W-1:0]  step_x,
    output logic signed [smsi_pkg::OUT_W-1:0]  step_y,
    output logic [smsi_pkg::PWR_W-1:0]         drive_power,
    output logic                               segment_end
);
    import smsi_pkg::*;

    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int PSUM_W = PACC_W + 1;

    // Step generator
    logic                     gen_busy_reg;
    logic [STEP_W-1:0]        k_reg;
    seg_t                     seg_reg;
    logic [STEP_W-1:0]        rx_reg, ry_reg, rp_reg;
    logic signed [PACC_W-1:0] accp_reg;

    // Pipeline
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_mx_reg, a_my_reg;
    logic [PWR_W-1:0]         a_p_reg;
    logic                     a_last_reg;
    logic                     b_valid_reg;
    logic signed [PROD_W-1:0] b_px_reg, b_py_reg;
    logic [2*PWR_W-1:0]       b_pp_reg;
    logic                     b_last_reg;
    logic                     c_valid_reg;
    logic signed [OUT_W-1:0]  c_sx_reg, c_sy_reg;
    logic [PWR_W-1:0]         c_pw_reg;
    logic                     c_last_reg;

    logic                     advance;
    logic                     gen_last;
    logic [STEP_W:0]          sum_x, sum_y, sum_p;
    logic                     cx, cy, cp;
    logic [STEP_W-1:0]        rx_next, ry_next, rp_next;
    logic signed [DIFF_W-1:0] mx, my;
    logic signed [PACC_W-1:0] accp_next;
    logic signed [PSUM_W-1:0] p_sum;
    logic [PWR_W-1:0]         p_clamped;
    logic [2*PWR_W:0]         pw_round;

    // Round half up at the Q8.8 gain point, then clip to the 32-bit range.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] s;
        r = v + PROD_W'(128);
        s = r >>> 8;
        if (s > $signed(PROD_W'({1'b0, {(OUT_W-1){1'b1}}})))
            round_sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (s < -$signed(PROD_W'({1'b0, 1'b1, {(OUT_W-1){1'b0}}})))
            round_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            round_sat = s[OUT_W-1:0];
    endfunction

    assign advance  = !c_valid_reg || out_ready;
    assign gen_last = k_reg == seg_reg.n;
    assign pop      = q_valid && (!gen_busy_reg || (advance && gen_last));

    // Carry the remainder of each difference across steps, as a Bresenham walk.
    always_comb
    begin
        sum_x = {1'b0, rx_reg} + {1'b0, seg_reg.rdx};
        sum_y = {1'b0, ry_reg} + {1'b0, seg_reg.rdy};
        sum_p = {1'b0, rp_reg} + {1'b0, seg_reg.rdp};
        cx    = sum_x >= {1'b0, seg_reg.n};
        cy    = sum_y >= {1'b0, seg_reg.n};
        cp    = sum_p >= {1'b0, seg_reg.n};
        rx_next = cx ? STEP_W'(sum_x - {1'b0, seg_reg.n}) : sum_x[STEP_W-1:0];
        ry_next = cy ? STEP_W'(sum_y - {1'b0, seg_reg.n}) : sum_y[STEP_W-1:0];
        rp_next = cp ? STEP_W'(sum_p - {1'b0, seg_reg.n}) : sum_p[STEP_W-1:0];
        mx = seg_reg.qdx + DIFF_W'(cx);
        my = seg_reg.qdy + DIFF_W'(cy);
        accp_next = accp_reg + seg_reg.qdp + PACC_W'(cp);
        p_sum = $signed(PSUM_W'({1'b0, seg_reg.p0})) + PSUM_W'(accp_next);
        if (p_sum[PSUM_W-1])
            p_clamped = '0;
        else if (p_sum[PSUM_W-2:PWR_W] != '0)
            p_clamped = '1;
        else
            p_clamped = p_sum[PWR_W-1:0];
    end

    assign pw_round = {1'b0, b_pp_reg} + (2*PWR_W+1)'(1 << (PWR_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_busy_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
                gen_busy_reg <= 1'b1;
            else if (advance && gen_busy_reg && gen_last)
                gen_busy_reg <= 1'b0;
            if (advance)
            begin
                a_valid_reg <= gen_busy_reg;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seg_reg  <= q_seg;
            k_reg    <= STEP_W'(1);
            rx_reg   <= '0;
            ry_reg   <= '0;
            rp_reg   <= '0;
            accp_reg <= '0;
        end
        else if (advance && gen_busy_reg)
        begin
            k_reg    <= k_reg + STEP_W'(1);
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rp_reg   <= rp_next;
            accp_reg <= accp_next;
        end
        if (advance)
        begin
            a_mx_reg   <= mx;
            a_my_reg   <= my;
            a_p_reg    <= p_clamped;
            a_last_reg <= gen_last;
            b_px_reg   <= PROD_W'(a_mx_reg * $signed({1'b0, x_gain}));
            b_py_reg   <= PROD_W'(a_my_reg * $signed({1'b0, y_gain}));
            b_pp_reg   <= a_p_reg * full_scale;
            b_last_reg <= a_last_reg;
            c_sx_reg   <= round_sat(b_px_reg);
            c_sy_reg   <= round_sat(b_py_reg);
            c_pw_reg   <= pw_round[2*PWR_W-1:PWR_W];
            c_last_reg <= b_last_reg;
        end
    end

    assign out_valid   = c_valid_reg;
    assign step_x      = c_sx_reg;
    assign step_y      = c_sy_reg;
    assign drive_power = c_pw_reg;
    assign segment_end = c_last_reg;

endmodule

// File: design/segment_micro_step_interpolator_core.sv
// Top level of the segment micro step interpolator: config registers and wiring.
//
// Points (x, y, relative power) come in one beat each. A point flagged as the
// first of a figure, or any point while none is stored, is only remembered and
// yields no output. Every other point closes a segment from the stored point and
// yields steps_per_segment output beats (0 acts as 1, values above MAX_STEPS are
// clipped): per micro step the relative x/y move times its Q8.8 gain, rounded
// half up and saturated to 32 bits, the linearly ramped power scaled to
// power_full_scale, and segment_end on the last step. The moves of a segment sum
// exactly to the point difference. The front end takes a point and then runs each
// segment point through a one-bit-per-cycle divider (25 quotient bits) that
// splits the x, y and power differences over the step count; while the front end
// is idle, points that yield no segment arrive at one per cycle. Two divided
// segments can wait in a queue. The back end emits one micro step per cycle while
// out_ready is high, with a three-stage pipeline (step walk, multiply, round)
// between queue and output. Write the configuration only while the block is idle.
module segment_micro_step_interpolator_core #(
    parameter int MAX_STEPS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [smsi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smsi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [smsi_pkg::POS_W-1:0]     x_pos,
    input  logic signed [smsi_pkg::POS_W-1:0]     y_pos,
    input  logic [smsi_pkg::PWR_W-1:0]            power_level,
    input  logic                                  first_point,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [smsi_pkg::OUT_W-1:0]     step_x,
    output logic signed [smsi_pkg::OUT_W-1:0]     step_y,
    output logic [smsi_pkg::PWR_W-1:0]            drive_power,
    output logic                                  segment_end
);
    import smsi_pkg::*;

    logic [STEP_W-1:0] steps_reg;
    logic [GAIN_W-1:0] x_gain_reg;
    logic [GAIN_W-1:0] y_gain_reg;
    logic [PWR_W-1:0]  full_scale_reg;

    logic push;
    seg_t push_seg;
    logic q_full;
    logic pop;
    logic q_valid;
    seg_t q_seg;

    // Register writes land at once; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg      <= STEP_W'(1);
            x_gain_reg     <= GAIN_W'(256);
            y_gain_reg     <= GAIN_W'(256);
            full_scale_reg <= PWR_W'(4095);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STEPS:      steps_reg      <= cfg_data[STEP_W-1:0];
                REG_X_GAIN:     x_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_Y_GAIN:     y_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_FULL_SCALE: full_scale_reg <= cfg_data[PWR_W-1:0];
                default:        steps_reg      <= steps_reg;
            endcase
        end
    end

    // Front end: hold the stored point, divide each new segment.
    smsi_front #(
        .MAX_STEPS(MAX_STEPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .power_level (power_level),
        .first_point (first_point),
        .steps_cfg   (steps_reg),
        .push        (push),
        .push_seg    (push_seg),
        .q_full      (q_full)
    );

    // Decouple divider and step generator.
    smsi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_seg (push_seg),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_seg    (q_seg)
    );

    // Back end: advance one micro step per beat.
    smsi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_seg       (q_seg),
        .pop         (pop),
        .x_gain      (x_gain_reg),
        .y_gain      (y_gain_reg),
        .full_scale  (full_scale_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .step_x      (step_x),
        .step_y      (step_y),
        .drive_power (drive_power),
        .segment_end (segment_end)
    );

endmodule

// File: verif/smsi_step_checker.sv
// Checker for the micro step interpolator: tracks config, predicts micro steps, compares.
module smsi_step_checker #(
    parameter int MAX_STEPS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [smsi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smsi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [smsi_pkg::POS_W-1:0]     x_pos,
    input  logic signed [smsi_pkg::POS_W-1:0]     y_pos,
    input  logic [smsi_pkg::PWR_W-1:0]            power_level,
    input  logic                                  first_point,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [smsi_pkg::OUT_W-1:0]     step_x,
    input  logic signed [smsi_pkg::OUT_W-1:0]     step_y,
    input  logic [smsi_pkg::PWR_W-1:0]            drive_power,
    input  logic                                  segment_end,
    output int                                    fail_count,
    output int                                    steps_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import smsi_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
        logic [PWR_W-1:0]        pwr;
        logic                    last;
    } micro_step_t;

    micro_step_t expected_steps[$];

    logic [STEP_W-1:0]        steps_reg;
    logic [GAIN_W-1:0]        x_gain_reg;
    logic [GAIN_W-1:0]        y_gain_reg;
    logic [PWR_W-1:0]         full_scale_reg;

    logic signed [POS_W-1:0]  anchor_x;
    logic signed [POS_W-1:0]  anchor_y;
    logic [PWR_W-1:0]         anchor_power;
    logic                     have_anchor;

    function automatic longint floor_div(longint a, longint b);
        if (a >= 0)
        begin
            return a / b;
        end
        return -((-a + b - 1) / b);
    endfunction

    // Gain is Q8.8: round half up, then clip to the 32 bit output range.
    function automatic logic signed [OUT_W-1:0] gain_scale(longint move, logic [GAIN_W-1:0] gain);
        longint v;
        v = floor_div(move * longint'(gain) + 128, 256);
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return v[OUT_W-1:0];
    endfunction

    task automatic flag_error(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic predict_segment(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                   logic [PWR_W-1:0] pw, logic first);
        longint n;
        longint dx;
        longint dy;
        longint dp;
        longint p0;
        longint p;
        micro_step_t s;
        if (first || !have_anchor)
        begin
            anchor_x     = x;
            anchor_y     = y;
            anchor_power = pw;
            have_anchor  = 1'b1;
            return;
        end
        n = longint'(steps_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_STEPS)
        begin
            n = MAX_STEPS;
        end
        dx = longint'(x) - longint'(anchor_x);
        dy = longint'(y) - longint'(anchor_y);
        p0 = longint'(anchor_power);
        dp = longint'(pw) - p0;
        for (longint k = 1; k <= n; k++)
        begin
            p = p0 + floor_div(dp * k, n);
            if (p < 0)
            begin
                p = 0;
            end
            if (p > 65535)
            begin
                p = 65535;
            end
            s.sx   = gain_scale(floor_div(dx * k, n) - floor_div(dx * (k - 1), n), x_gain_reg);
            s.sy   = gain_scale(floor_div(dy * k, n) - floor_div(dy * (k - 1), n), y_gain_reg);
            s.pwr  = PWR_W'((p * longint'(full_scale_reg) + 32768) >>> 16);
            s.last = (k == n);
            expected_steps.insert(expected_steps.size(), s);
        end
        anchor_x     = x;
        anchor_y     = y;
        anchor_power = pw;
    endtask

    task automatic check_step();
        micro_step_t want;
        if (expected_steps.size() == 0)
        begin
            flag_error($sformatf("unexpected micro step x=%0d y=%0d power=%0d end=%0b",
                                 step_x, step_y, drive_power, segment_end));
            return;
        end
        want = expected_steps.pop_front();
        if (step_x !== want.sx)
        begin
            flag_error($sformatf("step_x got %0d want %0d", step_x, want.sx));
        end
        if (step_y !== want.sy)
        begin
            flag_error($sformatf("step_y got %0d want %0d", step_y, want.sy));
        end
        if (drive_power !== want.pwr)
        begin
            flag_error($sformatf("drive_power got %0d want %0d", drive_power, want.pwr));
        end
        if (segment_end !== want.last)
        begin
            flag_error($sformatf("segment_end got %0b want %0b", segment_end, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg      = STEP_W'(1);
            x_gain_reg     = GAIN_W'(256);
            y_gain_reg     = GAIN_W'(256);
            full_scale_reg = PWR_W'(4095);
            anchor_x       = '0;
            anchor_y       = '0;
            anchor_power   = '0;
            have_anchor    = 1'b0;
            expected_steps.delete();
            fail_count     = 0;
            steps_pending  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_step();
            end
            if (in_valid && in_ready)
            begin
                predict_segment(x_pos, y_pos, power_level, first_point);
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_STEPS:      steps_reg      = cfg_data[STEP_W-1:0];
                    REG_X_GAIN:     x_gain_reg     = cfg_data[GAIN_W-1:0];
                    REG_Y_GAIN:     y_gain_reg     = cfg_data[GAIN_W-1:0];
                    REG_FULL_SCALE: full_scale_reg = cfg_data[PWR_W-1:0];
                    default:        ;
                endcase
            end
            steps_pending = expected_steps.size();
        end
    end

endmodule

// File: verif/tb_segment_micro_step_interpolator_core.sv
// Testbench top for the micro step interpolator: clock, reset, stimulus and verdict.
module tb_segment_micro_step_interpolator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import smsi_pkg::*;

    localparam int MAX_STEPS   = 64;
    localparam int CYCLE_LIMIT = 1_500_000;
    // Front end divider plus back end pipeline, with margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 40;
    localparam int PHASE_COUNT   = 10;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [POS_W-1:0]       x_pos;
    logic signed [POS_W-1:0]       y_pos;
    logic [PWR_W-1:0]              power_level;
    logic                          first_point;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [OUT_W-1:0]       step_x;
    logic signed [OUT_W-1:0]       step_y;
    logic [PWR_W-1:0]              drive_power;
    logic                          segment_end;

    int fail_count;
    int steps_pending;
    int cycle_count;

    // Random idling on both sides; cleared for the closing phases.
    bit idle_on;
    // Raised by the stimulus, cleared by the receiver once its long hold-off is over.
    bit hold_off_req;

    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;

    segment_micro_step_interpolator_core #(
        .MAX_STEPS(MAX_STEPS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .power_level(power_level),
        .first_point(first_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .step_x     (step_x),
        .step_y     (step_y),
        .drive_power(drive_power),
        .segment_end(segment_end)
    );

    smsi_step_checker #(
        .MAX_STEPS(MAX_STEPS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .power_level  (power_level),
        .first_point  (first_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .step_x       (step_x),
        .step_y       (step_y),
        .drive_power  (drive_power),
        .segment_end  (segment_end),
        .fail_count   (fail_count),
        .steps_pending(steps_pending)
    );

    // 12 ns period clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: abort a run that hangs.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Pick a position: short moves from the last point half of the time so segments
    // stay realistic, with full-range jumps and both extremes mixed in.
    function automatic logic signed [POS_W-1:0] pick_pos(logic signed [POS_W-1:0] near);
        logic signed [POS_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = POS_MIN;
            1:       v = POS_MAX;
            2, 3:    v = POS_W'($urandom);
            default: v = near + POS_W'($urandom_range(0, 2000)) - POS_W'(1000);
        endcase
        return v;
    endfunction

    function automatic logic [PWR_W-1:0] pick_power();
        logic [PWR_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            default: v = PWR_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one point beat and hold it until the block takes it. Valid stays
    // high afterwards; the next call or the settle step decides what follows.
    task automatic send_point(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                              logic [PWR_W-1:0] pw, logic first);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            // Idle burst on the input side.
            in_valid = 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        x_pos       = x;
        y_pos       = y;
        power_level = pw;
        first_point = first;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] steps, logic [CFG_DATA_W-1:0] xg,
                             logic [CFG_DATA_W-1:0] yg, logic [CFG_DATA_W-1:0] fs);
        write_reg(REG_STEPS, steps);
        write_reg(REG_X_GAIN, xg);
        write_reg(REG_Y_GAIN, yg);
        write_reg(REG_FULL_SCALE, fs);
    endtask

    // Drop valid, drain every expected micro step, then give the front end time
    // to finish any first point still in flight before config changes.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (steps_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: random ready bursts, stretches of steady ready, and one long
    // hold-off on request so the segment queue fills and in_ready drops.
    initial
    begin
        int span;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                span = $urandom_range(1, 10);
                repeat (span - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                span = $urandom_range(0, 30);
                repeat (span) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] steps;
        logic [CFG_DATA_W-1:0] xg;
        logic [CFG_DATA_W-1:0] yg;
        logic [CFG_DATA_W-1:0] fs;
        int                    n_items;
        int                    fig_len;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        x_pos        = '0;
        y_pos        = '0;
        power_level  = '0;
        first_point  = 1'b0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        cur_x        = '0;
        cur_y        = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting on reset config (single step, unit gains).
        // A plain point with nothing stored is only remembered.
        send_point(24'sd100, -24'sd200, 16'd1000, 1'b0);
        // Single step segments across the full position and power range.
        send_point(POS_MAX, POS_MAX, 16'hFFFF, 1'b0);
        send_point(POS_MIN, POS_MIN, 16'h0000, 1'b0);
        send_point(24'sd0, 24'sd0, 16'h8000, 1'b1);
        send_point(-24'sd1, 24'sd1, 16'h0001, 1'b0);
        wait_idle();

        // Zero step count acts as one; max x gain saturates large moves, y gain is zero.
        write_all(16'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_point(POS_MAX, POS_MIN, 16'hFFFF, 1'b0);
        send_point(POS_MIN, POS_MAX, 16'h0000, 1'b0);
        send_point(24'sd300, -24'sd300, 16'h7FFF, 1'b0);
        wait_idle();

        // Step count above the maximum is clipped; small moves spread over steps.
        write_all(16'd127, 16'd256, 16'd256, 16'd4095);
        send_point(24'sd7, -24'sd7, 16'd300, 1'b0);
        send_point(POS_MAX, POS_MIN, 16'hFFFF, 1'b0);
        send_point(-24'sd5, 24'sd5, 16'hFFFF, 1'b1);
        send_point(-24'sd300, 24'sd1000, 16'h0000, 1'b0);
        wait_idle();

        // Odd step count and fractional gain to exercise rounding.
        write_all(16'd3, 16'd385, 16'd129, 16'd1000);
        send_point(24'sd0, 24'sd0, 16'd10, 1'b1);
        send_point(-24'sd1, 24'sd2, 16'd11, 1'b0);
        send_point(24'sd1, -24'sd2, 16'd0, 1'b0);
        send_point(24'sd1000, 24'sd999, 16'hFFFF, 1'b0);
        wait_idle();

        // Upper data bits beyond the step field are dropped: zero, acting as one.
        write_reg(REG_STEPS, 16'hFF80);
        send_point(24'sd1234, -24'sd4321, 16'd5000, 1'b0);
        send_point(-24'sd1234, 24'sd4321, 16'd6000, 1'b0);

        // Random phases, each with its own settings; extremes come first.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    steps = 16'd64;
                    xg    = 16'd256;
                    yg    = 16'd256;
                    fs    = 16'd4095;
                end
                1:
                begin
                    steps = 16'd1;
                    xg    = 16'hFFFF;
                    yg    = 16'hFFFF;
                    fs    = 16'hFFFF;
                end
                2:
                begin
                    steps = 16'd0;
                    xg    = 16'h0000;
                    yg    = 16'h0000;
                    fs    = 16'h0000;
                end
                3:
                begin
                    steps = 16'd100;
                    xg    = CFG_DATA_W'($urandom);
                    yg    = CFG_DATA_W'($urandom);
                    fs    = CFG_DATA_W'($urandom);
                end
                default:
                begin
                    steps = ($urandom_range(0, 5) == 0) ? 16'd64
                                                         : CFG_DATA_W'($urandom_range(1, 12));
                    xg    = ($urandom_range(0, 1) == 0) ? 16'd256 : CFG_DATA_W'($urandom);
                    yg    = ($urandom_range(0, 1) == 0) ? 16'd256 : CFG_DATA_W'($urandom);
                    fs    = CFG_DATA_W'($urandom);
                end
            endcase
            write_all(steps, xg, yg, fs);

            // Flags are read by the receiver at the falling edge; set them mid-cycle.
            @(posedge clk);
            if (phase == 3)
            begin
                hold_off_req = 1'b1;
            end
            if (phase >= PHASE_COUNT - 2)
            begin
                idle_on = 1'b0;
            end

            // Figures: a start point, then a run of segment points.
            n_items = 0;
            while (n_items < PHASE_ITEMS)
            begin
                cur_x = pick_pos(cur_x);
                cur_y = pick_pos(cur_y);
                send_point(cur_x, cur_y, pick_power(), 1'b1);
                n_items++;
                fig_len = $urandom_range(1, 10);
                repeat (fig_len)
                begin
                    cur_x = pick_pos(cur_x);
                    cur_y = pick_pos(cur_y);
                    send_point(cur_x, cur_y, pick_power(), 1'b0);
                    n_items++;
                end
            end
        end

        // Drain, then watch a little longer for stray beats.
        @(negedge clk);
        in_valid = 1'b0;
        while (steps_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && steps_pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: segment_micro_step_interpolator_core.f
design/smsi_pkg.sv
design/smsi_div.sv
design/smsi_front.sv
design/smsi_queue.sv
design/smsi_back.sv
design/segment_micro_step_interpolator_core.sv
verif/smsi_step_checker.sv
verif/tb_segment_micro_step_interpolator_core.sv
